FILE: hw/rtl/szs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szs_pkg
// Shared types, constants and table functions of the sphere z-buffer shader.
// ----------------------------------------------------------------------------
package szs_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_PLOT   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [15:0] DEPTH_EMPTY = 16'hFFFF;
  localparam logic [2:0]  SHADE_EMPTY = 3'd6;
  localparam int          Z_BIAS      = 7 * 1024;
  localparam int          NUM_W       = 32;
  localparam int          DEN_W       = 18;
  localparam logic [7:0]  CHAR_SPACE  = 8'h20;

  typedef logic signed [15:0] q15_t;

  function automatic q15_t sin_q15(input logic [15:0] phase);
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    q15_t res;
    f = {50'd0, phase[13:0]};
    if (phase[14]) begin
      f = 64'd16384 - f;
    end
    t  = f * 64'd102944;
    t2 = (t * t) >> 30;
    r  = (64'd1 << 30) - t2 / 64'd72;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd42;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd20;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd6;
    s  = (t * r) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    res = q15_t'(v[15:0]);
    if (phase[15]) begin
      res = -res;
    end
    return res;
  endfunction

  function automatic logic [7:0] shade_char(input logic [2:0] code);
    logic [7:0] ch;
    case (code)
      3'd0: ch = 8'h2D;
      3'd1: ch = 8'h2E;
      3'd2: ch = 8'h2B;
      3'd3: ch = 8'h2A;
      3'd4: ch = 8'h23;
      3'd5: ch = 8'h40;
      default: ch = CHAR_SPACE;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/szs_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szs_cmd_if
// Request channel of the shader: opcode, grid indexes and row number.
// ----------------------------------------------------------------------------
interface szs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] u_index;
  logic [6:0] v_index;
  logic [4:0] row;

  modport source (output valid, opcode, u_index, v_index, row, input ready);
  modport sink (input valid, opcode, u_index, v_index, row, output ready);
endinterface

FILE: hw/rtl/szs_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szs_pix_if
// Result channel of the shader: one character of a row per transfer.
// ----------------------------------------------------------------------------
interface szs_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink (input valid, char_code, last, output ready);
endinterface

FILE: hw/rtl/sphere_zbuffer_shader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_zbuffer_shader_core
// Point renderer of a shaded sphere into a character frame with a depth store.
// ----------------------------------------------------------------------------
// Requests arrive on cmd (valid/ready). A clear request empties the frame, a
// plot request projects one grid sample of the sphere and keeps it if it is
// nearer than the stored depth, and a read request emits the COLS characters
// of one row on pix, with last set on the final one. Light direction is set
// through the APB port (light_x at 0, light_z at 4).
// The sequencer shares one 32x17 multiplier among the projection and lighting
// products and one bit-serial divider among both divisions, and cmd.ready is
// high only while the sequencer is idle. The time of a plot is set mostly by
// the two 32-step divisions of the projection. A clear writes one cell per
// cycle through the single write port of the frame memory. A read fetches each
// character from the frame memory and then presents it on pix; a stall on pix
// holds the character and the sequencer until it is taken.
// After reset the same clearing pass runs before the first request is taken;
// configuration writes are accepted at all times outside reset.
// ----------------------------------------------------------------------------
module sphere_zbuffer_shader_core #(
  parameter int STEPS = 100,
  parameter int COLS  = 60,
  parameter int ROWS  = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  szs_cmd_if.sink     cmd,
  szs_pix_if.source   pix
);

  localparam int CELLS  = ROWS * COLS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PERSP  = (COLS * 3) / 4;
  localparam int DEN0   = PERSP * 1024;
  localparam int NW     = szs_pkg::NUM_W;
  localparam int DW     = szs_pkg::DEN_W;
  localparam int DCW    = $clog2(NW);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_P0   = 5'd2;
  localparam logic [4:0] S_P1   = 5'd3;
  localparam logic [4:0] S_P2   = 5'd4;
  localparam logic [4:0] S_P3   = 5'd5;
  localparam logic [4:0] S_P4   = 5'd6;
  localparam logic [4:0] S_P5   = 5'd7;
  localparam logic [4:0] S_P6   = 5'd8;
  localparam logic [4:0] S_DIV  = 5'd9;
  localparam logic [4:0] S_P7   = 5'd10;
  localparam logic [4:0] S_P8   = 5'd11;
  localparam logic [4:0] S_P9   = 5'd12;
  localparam logic [4:0] S_ADR  = 5'd13;
  localparam logic [4:0] S_CMP  = 5'd14;
  localparam logic [4:0] S_L0   = 5'd15;
  localparam logic [4:0] S_L1   = 5'd16;
  localparam logic [4:0] S_L2   = 5'd17;
  localparam logic [4:0] S_RR0  = 5'd18;
  localparam logic [4:0] S_RR1  = 5'd19;
  localparam logic [4:0] S_RR2  = 5'd20;

  szs_pkg::q15_t su_tab [128];
  szs_pkg::q15_t cu_tab [128];
  szs_pkg::q15_t sv_tab [128];
  szs_pkg::q15_t cv_tab [128];

  for (genvar gi = 0; gi < 128; gi++) begin : g_tab
    localparam logic [15:0] PU = 16'((gi * 32768) / STEPS);
    localparam logic [15:0] PV = 16'((gi * 65536) / STEPS);
    assign su_tab[gi] = szs_pkg::sin_q15(PU);
    assign cu_tab[gi] = szs_pkg::sin_q15(PU + 16'd16384);
    assign sv_tab[gi] = szs_pkg::sin_q15(PV);
    assign cv_tab[gi] = szs_pkg::sin_q15(PV + 16'd16384);
  end

  logic [4:0]          state;
  logic [CELL_W-1:0]   cnt;
  logic signed [15:0]  light_x;
  logic signed [15:0]  light_z;
  logic                out_valid;
  logic [7:0]          out_char;
  logic                out_last;

  szs_pkg::q15_t       su;
  szs_pkg::q15_t       cu;
  szs_pkg::q15_t       sv;
  szs_pkg::q15_t       cv;
  logic signed [31:0]  nx;
  logic signed [31:0]  nz;
  logic signed [15:0]  x10;
  logic signed [15:0]  y10;
  logic [15:0]         z10;
  logic [16:0]         den;
  logic signed [48:0]  prod;
  logic signed [48:0]  acc;
  logic [NW-1:0]       num;
  logic                neg;
  logic [DW-1:0]       dvs;
  logic [DW-1:0]       rem;
  logic [NW-1:0]       quo;
  logic [DCW-1:0]      div_cnt;
  logic                div_row;
  logic [COL_W-1:0]    sx;
  logic [ROW_W-1:0]    sy;
  logic [CELL_W-1:0]   idx;
  logic [4:0]          rd_row;
  logic [COL_W-1:0]    rd_col;

  logic [18:0]         mem [CELLS];
  logic [18:0]         mem_q;
  logic                mem_we;
  logic [CELL_W-1:0]   mem_waddr;
  logic [18:0]         mem_wdata;
  logic [CELL_W-1:0]   mem_raddr;

  logic signed [31:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [48:0]  mul_p;
  logic signed [36:0]  mx;
  logic signed [36:0]  mz;
  logic signed [20:0]  my;
  logic signed [15:0]  x10_c;
  logic signed [15:0]  y10_c;
  logic signed [16:0]  z10_c;
  logic signed [49:0]  sum;
  logic [49:0]         mag;
  logic [DW:0]         rem_sh;
  logic                div_ge;
  logic [DW-1:0]       rem_n;
  logic [NW-1:0]       quo_n;
  logic                div_ok;
  logic [CELL_W-1:0]   idx_c;
  logic [CELL_W-1:0]   rd_addr;
  logic                rd_row_ok;
  logic [52:0]         shade_w;
  logic [2:0]          shade_c;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? 32'(light_z) : 32'(light_x);

  assign cmd.ready     = (state == S_IDLE);
  assign pix.valid     = out_valid;
  assign pix.char_code = out_char;
  assign pix.last      = out_last;

  always_comb begin
    case (state)
      S_P0: begin
        mul_a = 32'(su);
        mul_b = 17'(cv);
      end
      S_P1: begin
        mul_a = 32'(su);
        mul_b = 17'(sv);
      end
      S_P4: begin
        mul_a = 32'(x10);
        mul_b = 17'(PERSP);
      end
      S_P5: begin
        mul_a = 32'($signed({1'b0, den}));
        mul_b = 17'(COLS / 2);
      end
      S_P7: begin
        mul_a = 32'(y10);
        mul_b = 17'(PERSP);
      end
      S_P8: begin
        mul_a = 32'($signed({1'b0, den}));
        mul_b = 17'(ROWS);
      end
      S_L0: begin
        mul_a = nx;
        mul_b = 17'(light_x);
      end
      default: begin
        mul_a = nz;
        mul_b = 17'(light_z);
      end
    endcase
    mul_p = mul_a * mul_b;

    mx    = 37'(nx) * 37'sd27;
    mz    = 37'(nz) * 37'sd27;
    my    = 21'(cu) * 21'sd27;
    x10_c = 16'((mx + (mx[36] ? 37'sd1048575 : 37'sd0)) >>> 20);
    z10_c = 17'((mz + (mz[36] ? 37'sd1048575 : 37'sd0)) >>> 20) + 17'(szs_pkg::Z_BIAS);
    y10_c = 16'((my + (my[20] ? 21'sd31 : 21'sd0)) >>> 5);

    sum = 50'(acc) + 50'(prod);
    mag = sum[49] ? 50'(-sum) : 50'(sum);

    rem_sh = {rem, num[NW-1]};
    div_ge = (rem_sh >= {1'b0, dvs});
    rem_n  = div_ge ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
    quo_n  = {quo[NW-2:0], div_ge};
    div_ok = (!neg || quo_n == '0) &&
             (quo_n < (div_row ? NW'(ROWS) : NW'(COLS)));

    idx_c     = CELL_W'(sy) * CELL_W'(COLS) + CELL_W'(sx);
    rd_addr   = CELL_W'(rd_row) * CELL_W'(COLS) + CELL_W'(rd_col);
    rd_row_ok = (32'(rd_row) < 32'(ROWS));

    shade_w = 53'(sum[49:0]) * 53'd6;
    if (sum <= 0) begin
      shade_c = 3'd0;
    end else if (shade_w[52:45] > 8'd5) begin
      shade_c = 3'd5;
    end else begin
      shade_c = shade_w[47:45];
    end

    mem_we    = (state == S_CLR) || (state == S_L2);
    mem_waddr = (state == S_CLR) ? cnt : idx;
    mem_wdata = (state == S_CLR) ? {szs_pkg::DEPTH_EMPTY, szs_pkg::SHADE_EMPTY} :
                                   {z10, shade_c};
    mem_raddr = (state == S_ADR) ? idx_c : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      light_x   <= 16'sd32767;
      light_z   <= 16'sd0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) begin
          light_z <= pwdata[15:0];
        end else begin
          light_x <= pwdata[15:0];
        end
      end
      prod <= mul_p;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            su     <= su_tab[cmd.u_index];
            cu     <= cu_tab[cmd.u_index];
            sv     <= sv_tab[cmd.v_index];
            cv     <= cv_tab[cmd.v_index];
            rd_row <= cmd.row;
            rd_col <= '0;
            cnt    <= '0;
            case (cmd.opcode)
              szs_pkg::OP_CLEAR: state <= S_CLR;
              szs_pkg::OP_PLOT:  state <= S_P0;
              szs_pkg::OP_READ:  state <= S_RR0;
              default:           state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CELL_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin
          nx    <= prod[31:0];
          state <= S_P2;
        end
        S_P2: begin
          nz    <= prod[31:0];
          state <= S_P3;
        end
        S_P3: begin
          x10 <= x10_c;
          y10 <= y10_c;
          z10 <= z10_c[15:0];
          den <= 17'(DEN0) + 17'(z10_c);
          if (z10_c <= 0) begin
            state <= S_IDLE;
          end else begin
            state <= S_P4;
          end
        end
        S_P4: state <= S_P5;
        S_P5: begin
          acc   <= prod;
          state <= S_P6;
        end
        S_P6: begin
          neg     <= sum[49];
          num     <= mag[NW-1:0];
          dvs     <= DW'(den);
          rem     <= '0;
          quo     <= '0;
          div_cnt <= '0;
          div_row <= 1'b0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= rem_n;
          quo     <= quo_n;
          num     <= {num[NW-2:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCW'(NW - 1)) begin
            if (!div_ok) begin
              state <= S_IDLE;
            end else if (div_row) begin
              sy    <= quo_n[ROW_W-1:0];
              state <= S_ADR;
            end else begin
              sx    <= quo_n[COL_W-1:0];
              state <= S_P7;
            end
          end
        end
        S_P7: state <= S_P8;
        S_P8: begin
          acc   <= prod;
          state <= S_P9;
        end
        S_P9: begin
          neg     <= sum[49];
          num     <= mag[NW-1:0];
          dvs     <= {den, 1'b0};
          rem     <= '0;
          quo     <= '0;
          div_cnt <= '0;
          div_row <= 1'b1;
          state   <= S_DIV;
        end
        S_ADR: begin
          idx   <= idx_c;
          state <= S_CMP;
        end
        S_CMP: begin
          if (z10 < mem_q[18:3]) begin
            state <= S_L0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_L0: state <= S_L1;
        S_L1: begin
          acc   <= prod;
          state <= S_L2;
        end
        S_L2: state <= S_IDLE;
        S_RR0: state <= S_RR1;
        S_RR1: begin
          out_char  <= rd_row_ok ? szs_pkg::shade_char(mem_q[2:0]) : szs_pkg::CHAR_SPACE;
          out_last  <= (rd_col == COL_W'(COLS - 1));
          out_valid <= 1'b1;
          state     <= S_RR2;
        end
        S_RR2: begin
          if (pix.ready) begin
            out_valid <= 1'b0;
            rd_col    <= rd_col + 1'b1;
            state     <= out_last ? S_IDLE : S_RR0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pix_in_read: assert property (@(posedge clk) disable iff (rst)
    pix.valid |-> (state == S_RR2))
    else $error("result shown outside the row read");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !pix.valid)
    else $error("request taken while a character is pending");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt != DCW'(NW - 1)) |=> (state == S_DIV))
    else $error("division left early");

  a_depth_positive: assert property (@(posedge clk) disable iff (rst)
    (state == S_L2) |-> (z10 != 16'd0 && z10 != szs_pkg::DEPTH_EMPTY))
    else $error("invalid depth written to the frame");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the sphere z-buffer shader core.
// A queue-fed driver sends clear, plot, read-row and unused-opcode requests
// with random gaps, while a scoreboard renders the same requests into its own
// depth and shade frames and checks every character that comes back. The
// light is reprogrammed over APB between phases, its extremes included.
// ----------------------------------------------------------------------------
module tb;

  localparam int NCOLS     = 60;
  localparam int NROWS     = 30;
  localparam int NSTEPS    = 100;
  localparam int NCELLS    = NROWS * NCOLS;
  localparam int PERSP     = (NCOLS * 3) / 4;
  localparam int SETTLE    = 2500;
  localparam int MAX_CYCLE = 1000000;
  localparam logic [2:0] ADDR_LIGHT_X = 3'd0;
  localparam logic [2:0] ADDR_LIGHT_Z = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] u_index;
    logic [6:0] v_index;
    logic [4:0] row;
  } request_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } pixel_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  szs_cmd_if cmd_bus ();
  szs_pix_if pix_bus ();

  request_t pending_q[$];
  pixel_t   frame_chars_q[$];
  logic [15:0] depth_frame [NCELLS];
  logic [2:0]  shade_frame [NCELLS];
  int light_x_q;
  int light_z_q;

  int errors;
  int sent_cnt;
  int rows_read;
  int chars_seen;
  int cycle_cnt;
  int hold_left;
  bit hold_done;

  sphere_zbuffer_shader_core u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd_bus), .pix(pix_bus)
  );

  function automatic longint wave_sin(input logic [15:0] ph);
    longint unsigned f, t, t2, r, s, v;
    f = ph[13:0];
    if (ph[14]) begin
      f = 16384 - f;
    end
    t  = f * 102944;
    t2 = (t * t) >> 30;
    r  = (64'd1 << 30) - t2 / 72;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 42;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 20;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 6;
    s  = (t * r) >> 30;
    v  = (s + 16384) >> 15;
    if (v > 32767) begin
      v = 32767;
    end
    return ph[15] ? -longint'(v) : longint'(v);
  endfunction

  function automatic logic [7:0] glyph_of(input logic [2:0] code);
    case (code)
      3'd0: return 8'h2D;
      3'd1: return 8'h2E;
      3'd2: return 8'h2B;
      3'd3: return 8'h2A;
      3'd4: return 8'h23;
      3'd5: return 8'h40;
      default: return 8'h20;
    endcase
  endfunction

  function automatic void wipe_frame();
    for (int i = 0; i < NCELLS; i++) begin
      depth_frame[i] = 16'hFFFF;
      shade_frame[i] = 3'd6;
    end
  endfunction

  function automatic void plot_point(input int ui, input int vi);
    logic [15:0] pu, pv;
    longint su, cu, sv, cv, nx, nz, x10, y10, z10, den, sx, sy, d, sh;
    int idx;
    pu  = 16'((ui * 32768) / NSTEPS);
    pv  = 16'((vi * 65536) / NSTEPS);
    su  = wave_sin(pu);
    cu  = wave_sin(pu + 16'd16384);
    sv  = wave_sin(pv);
    cv  = wave_sin(pv + 16'd16384);
    nx  = su * cv;
    nz  = su * sv;
    x10 = (27 * nx) / (longint'(1) << 20);
    y10 = (27 * cu) / 32;
    z10 = (27 * nz) / (longint'(1) << 20) + 7 * 1024;
    if (z10 <= 0) begin
      return;
    end
    den = PERSP * 1024 + z10;
    sx  = (x10 * PERSP + (NCOLS / 2) * den) / den;
    sy  = (y10 * PERSP + NROWS * den) / (2 * den);
    if (sx < 0 || sx >= NCOLS || sy < 0 || sy >= NROWS) begin
      return;
    end
    idx = int'(sy * NCOLS + sx);
    if (z10 >= longint'(depth_frame[idx])) begin
      return;
    end
    depth_frame[idx] = 16'(z10);
    d = nx * light_x_q + nz * light_z_q;
    if (d <= 0) begin
      shade_frame[idx] = 3'd0;
    end else begin
      sh = (d * 6) >>> 45;
      shade_frame[idx] = (sh > 5) ? 3'd5 : 3'(sh);
    end
  endfunction

  function automatic void render_request(input request_t req);
    pixel_t px;
    case (req.opcode)
      szs_pkg::OP_CLEAR: wipe_frame();
      szs_pkg::OP_PLOT:  plot_point(req.u_index, req.v_index);
      szs_pkg::OP_READ: begin
        rows_read++;
        for (int c = 0; c < NCOLS; c++) begin
          px.char_code = (req.row < NROWS) ?
                         glyph_of(shade_frame[req.row * NCOLS + c]) :
                         szs_pkg::CHAR_SPACE;
          px.last = (c == NCOLS - 1);
          frame_chars_q.push_back(px);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic request_t make_req(input logic [1:0] op, input int u, input int v,
                                        input int r);
    request_t q;
    q.opcode  = op;
    q.u_index = 7'(u);
    q.v_index = 7'(v);
    q.row     = 5'(r);
    return q;
  endfunction

  function automatic request_t random_req();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(9) == 0) begin
        return make_req(szs_pkg::OP_PLOT, $urandom_range(127), $urandom_range(127),
                        $urandom_range(31));
      end
      return make_req(szs_pkg::OP_PLOT, $urandom_range(99), $urandom_range(99),
                      $urandom_range(31));
    end else if (pick < 91) begin
      return make_req(szs_pkg::OP_READ, $urandom_range(127), $urandom_range(127),
                      $urandom_range(31));
    end else if (pick < 96) begin
      return make_req(szs_pkg::OP_UNUSED, $urandom_range(127), $urandom_range(127),
                      $urandom_range(31));
    end
    return make_req(szs_pkg::OP_CLEAR, $urandom_range(127), $urandom_range(127),
                    $urandom_range(31));
  endfunction

  task automatic wait_quiet();
    while (pending_q.size() != 0 || cmd_bus.valid || frame_chars_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{16{value[15]}}, value[15:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_LIGHT_X) begin
      light_x_q = int'($signed(value[15:0]));
    end else begin
      light_z_q = int'($signed(value[15:0]));
    end
  endtask

  task automatic set_light(input int lx, input int lz);
    wait_quiet();
    apb_write(ADDR_LIGHT_X, lx);
    apb_write(ADDR_LIGHT_Z, lz);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        render_request(make_req(cmd_bus.opcode, cmd_bus.u_index, cmd_bus.v_index,
                                cmd_bus.row));
        sent_cnt++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending_q.size() != 0 &&
            ((sent_cnt > 200 && sent_cnt < 290) || $urandom_range(99) >= 30)) begin
          request_t nxt;
          nxt = pending_q.pop_front();
          cmd_bus.valid   <= 1'b1;
          cmd_bus.opcode  <= nxt.opcode;
          cmd_bus.u_index <= nxt.u_index;
          cmd_bus.v_index <= nxt.v_index;
          cmd_bus.row     <= nxt.row;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_seen >= 2000) begin
      hold_done <= 1'b1;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pix_bus.ready <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        chars_seen++;
        if (frame_chars_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected character %h last %b", pix_bus.char_code, pix_bus.last);
          end
        end else begin
          pixel_t want;
          want = frame_chars_q.pop_front();
          if (want.char_code !== pix_bus.char_code || want.last !== pix_bus.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       want.char_code, want.last, pix_bus.char_code, pix_bus.last);
            end
          end
        end
      end
      if (hold_left > 0) begin
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= (chars_seen > 4000 && chars_seen < 5500) ||
                         ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int settings [6][2];
    cmd_bus.valid   = 1'b0;
    cmd_bus.opcode  = szs_pkg::OP_CLEAR;
    cmd_bus.u_index = '0;
    cmd_bus.v_index = '0;
    cmd_bus.row     = '0;
    pix_bus.ready   = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    sent_cnt = 0;
    rows_read = 0;
    chars_seen = 0;
    cycle_cnt = 0;
    light_x_q = 32767;
    light_z_q = 0;
    wipe_frame();
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    pending_q.push_back(make_req(szs_pkg::OP_READ, 0, 0, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 0, 0, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 99, 99, 31));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 127, 127, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 50, 0, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 50, 0, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 50, 25, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 50, 75, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 25, 50, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 75, 10, 0));
    pending_q.push_back(make_req(szs_pkg::OP_PLOT, 100, 0, 0));
    pending_q.push_back(make_req(szs_pkg::OP_UNUSED, 127, 127, 31));
    pending_q.push_back(make_req(szs_pkg::OP_READ, 0, 0, 0));
    pending_q.push_back(make_req(szs_pkg::OP_READ, 0, 0, 15));
    pending_q.push_back(make_req(szs_pkg::OP_READ, 0, 0, 29));
    pending_q.push_back(make_req(szs_pkg::OP_READ, 0, 0, 30));
    pending_q.push_back(make_req(szs_pkg::OP_READ, 127, 127, 31));
    pending_q.push_back(make_req(szs_pkg::OP_CLEAR, 0, 0, 0));
    pending_q.push_back(make_req(szs_pkg::OP_READ, 0, 0, 15));

    settings = '{'{-32768, -32768}, '{32767, 32767}, '{0, 0}, '{23170, -23170},
                 '{-32768, 32767}, '{0, 0}};
    settings[5][0] = int'($urandom_range(65535));
    settings[5][1] = int'($urandom_range(65535));
    for (int ph = 0; ph < 6; ph++) begin
      set_light(settings[ph][0], settings[ph][1]);
      pending_q.push_back(make_req(szs_pkg::OP_CLEAR, 0, 0, 0));
      for (int k = 0; k < 66; k++) begin
        pending_q.push_back(random_req());
      end
      for (int r = 0; r < NROWS; r += 6) begin
        pending_q.push_back(make_req(szs_pkg::OP_READ, 0, 0, r + $urandom_range(5)));
      end
    end
    wait_quiet();

    $display("Sent %0d requests over six light settings; %0d rows and %0d characters checked.",
             sent_cnt, rows_read, chars_seen);
    if (errors == 0 && frame_chars_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: sphere_zbuffer_shader_core.f
hw/rtl/szs_pkg.sv
hw/rtl/szs_cmd_if.sv
hw/rtl/szs_pix_if.sv
hw/rtl/sphere_zbuffer_shader_core.sv
tb/tb.sv
